FILE: rtl/lbm_d2q9_cell_collision_macros.svh
// Assertion macros shared by the collision RTL.
`ifndef LBM_D2Q9_CELL_COLLISION_MACROS_SVH
`define LBM_D2Q9_CELL_COLLISION_MACROS_SVH

// Generic clocked assertion, disabled during active-low reset.
`define LBMC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define LBMC_CHECK(lbl, prop, msg) \
    `LBMC_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

FILE: rtl/lbmc_pkg.sv
// Types, constants and fixed-point helpers of the D2Q9 collision pipeline.
package lbmc_pkg;

    localparam int FRAC      = 28;
    localparam int MOM_BITS  = 35;   // momentum sum of six words
    localparam int RHO_BITS  = 36;   // density sum of nine words
    localparam int GRP_BITS  = 34;   // sum of three words
    localparam int QBITS     = 33;   // quotient bits kept before saturation
    localparam int RBITS     = 32;   // square root bits

    typedef logic signed [31:0] t_word;
    typedef t_word [8:0] t_dens;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
    localparam t_word WORD_MAX = 32'sh7FFFFFFF;
    localparam t_word WORD_MIN = 32'sh80000000;

    localparam t_word ONE_Q  = 32'sd268435456;
    localparam t_word W0_Q   = 32'sd119304647;
    localparam t_word W1_Q   = 32'sd29826162;
    localparam t_word W2_Q   = 32'sd7456540;
    localparam t_word K45_Q  = 32'sd1207959552;
    localparam t_word K15_Q  = 32'sd402653184;
    localparam t_word TWO3_Q = 32'sd178956971;

    localparam logic [1:0] KIND_FLUID = 2'd0;
    localparam logic [1:0] KIND_OBST  = 2'd1;
    localparam logic [1:0] KIND_HALO  = 2'd2;

    localparam int          CFG_ADDR_BITS = 3;
    localparam logic        REG_RELAX     = 1'b0;
    localparam logic [29:0] RELAX_RESET   = 30'd268435456;

    // pipeline timing, in cycles
    localparam int DIV_LAT    = QBITS + 2;
    localparam int SQRT_LAT   = RBITS + 2;
    localparam int COLL_LAT   = 8;
    localparam int SQ_TAP     = 2;
    localparam int LAT_T0     = 2 + DIV_LAT;
    localparam int ALIGN      = SQ_TAP + SQRT_LAT - COLL_LAT;
    localparam int LAT_ALIGN  = LAT_T0 + SQ_TAP + SQRT_LAT;
    localparam int RESULT_EDGES = LAT_ALIGN + 2;

    typedef struct packed {
        logic signed [31:0] in_rest;
        logic signed [31:0] in_east;
        logic signed [31:0] in_north;
        logic signed [31:0] in_west;
        logic signed [31:0] in_south;
        logic signed [31:0] in_northeast;
        logic signed [31:0] in_northwest;
        logic signed [31:0] in_southwest;
        logic signed [31:0] in_southeast;
        logic [1:0]         cell_kind;
    } t_cell_in;

    typedef struct packed {
        logic signed [31:0] out_rest;
        logic signed [31:0] out_east;
        logic signed [31:0] out_north;
        logic signed [31:0] out_west;
        logic signed [31:0] out_south;
        logic signed [31:0] out_northeast;
        logic signed [31:0] out_northwest;
        logic signed [31:0] out_southwest;
        logic signed [31:0] out_southeast;
        logic [30:0]        cell_speed;
    } t_cell_out;

    function automatic t_word sat_w(input logic signed [63:0] x);
        t_word y;
        if (x > SAT_HI) y = WORD_MAX;
        else if (x < SAT_LO) y = WORD_MIN;
        else y = x[31:0];
        return y;
    endfunction

    // product scaled back by 2^28, floor, saturated
    function automatic t_word mulq_fin(input logic signed [63:0] p);
        return sat_w(p >>> FRAC);
    endfunction

    function automatic t_dens cell_dens(input t_cell_in c);
        t_dens d;
        d[0] = c.in_rest;      d[1] = c.in_east;      d[2] = c.in_north;
        d[3] = c.in_west;      d[4] = c.in_south;     d[5] = c.in_northeast;
        d[6] = c.in_northwest; d[7] = c.in_southwest; d[8] = c.in_southeast;
        return d;
    endfunction

    function automatic t_cell_out make_out(input t_dens d, input logic [30:0] spd);
        t_cell_out o;
        o.out_rest      = d[0]; o.out_east      = d[1]; o.out_north     = d[2];
        o.out_west      = d[3]; o.out_south     = d[4]; o.out_northeast = d[5];
        o.out_northwest = d[6]; o.out_southwest = d[7]; o.out_southeast = d[8];
        o.cell_speed    = spd;
        return o;
    endfunction

    function automatic int opp_dir(input int i);
        int r;
        unique case (i)
            1: r = 3;
            2: r = 4;
            3: r = 1;
            4: r = 2;
            5: r = 7;
            6: r = 8;
            7: r = 5;
            8: r = 6;
            default: r = 0;
        endcase
        return r;
    endfunction

    // velocity term of a direction: 0 ux, 1 uy, 2 ux+uy, 3 ux-uy
    function automatic int eq_vel(input int i);
        int r;
        unique case (i)
            1, 3: r = 0;
            2, 4: r = 1;
            5, 7: r = 2;
            default: r = 3;
        endcase
        return r;
    endfunction

    function automatic logic eq_plus(input int i);
        return (i == 1) || (i == 2) || (i == 5) || (i == 8);
    endfunction

endpackage

FILE: rtl/lbmc_div.sv
// Pipelined restoring divider: momentum * 2^28 / density, saturated.
module lbmc_div (
    input  logic                              i_clk,
    input  logic signed [lbmc_pkg::MOM_BITS-1:0] i_num,
    input  logic signed [lbmc_pkg::RHO_BITS-1:0] i_den,
    output lbmc_pkg::t_word                   o_quo
);
    localparam int QB = lbmc_pkg::QBITS;
    localparam int NB = lbmc_pkg::MOM_BITS;
    localparam int DB = lbmc_pkg::RHO_BITS;

    logic [NB-1:0] w_an;
    logic [DB-1:0] w_ad;

    logic [DB-1:0] r_rem  [0:QB];
    logic [DB-1:0] r_ad   [0:QB];
    logic [4:0]    r_lo   [0:QB];
    logic [QB-1:0] r_q    [0:QB];
    logic          r_neg  [0:QB];
    logic          r_ovf  [0:QB];
    logic          r_zero [0:QB];
    lbmc_pkg::t_word r_quo;

    assign w_an = i_num[NB-1] ? (~i_num + 1'b1) : i_num;
    assign w_ad = i_den[DB-1] ? (~i_den + 1'b1) : i_den;

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DB'(w_an >> 5);
        r_lo[0]   <= w_an[4:0];
        r_ad[0]   <= w_ad;
        r_q[0]    <= '0;
        r_neg[0]  <= i_num[NB-1] ^ i_den[DB-1];
        // quotient needs more than 33 bits
        r_ovf[0]  <= {6'b0, w_an} >= {w_ad, 5'b0};
        r_zero[0] <= (i_den == '0);
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int K = QB - 1 - j;
        logic          w_bit;
        logic [DB:0]   w_trial;
        logic          w_ge;

        if (K >= lbmc_pkg::FRAC) begin : g_num
            assign w_bit = r_lo[j][K-lbmc_pkg::FRAC];
        end else begin : g_zero
            assign w_bit = 1'b0;
        end

        assign w_trial = {r_rem[j], w_bit};
        assign w_ge    = w_trial >= {1'b0, r_ad[j]};

        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= w_ge ? DB'(w_trial - {1'b0, r_ad[j]}) : w_trial[DB-1:0];
            r_q[j+1]    <= {r_q[j][QB-2:0], w_ge};
            r_ad[j+1]   <= r_ad[j];
            r_lo[j+1]   <= r_lo[j];
            r_neg[j+1]  <= r_neg[j];
            r_ovf[j+1]  <= r_ovf[j];
            r_zero[j+1] <= r_zero[j];
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_zero[QB]) begin
            r_quo <= '0;
        end else if (r_ovf[QB]) begin
            r_quo <= r_neg[QB] ? lbmc_pkg::WORD_MIN : lbmc_pkg::WORD_MAX;
        end else if (!r_neg[QB]) begin
            r_quo <= (r_q[QB] > 33'h07FFFFFFF) ? lbmc_pkg::WORD_MAX : r_q[QB][31:0];
        end else begin
            r_quo <= (r_q[QB] > 33'h080000000) ? lbmc_pkg::WORD_MIN
                                                : (~r_q[QB][31:0] + 32'd1);
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: rtl/lbmc_sqrt.sv
// Pipelined integer square root of the squared speed, saturated to 31 bits.
module lbmc_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_sq,
    output logic [30:0] o_root
);
    localparam int RB = lbmc_pkg::RBITS;
    localparam int MB = RB + 2;

    logic [63:0]   r_v    [0:RB];
    logic [MB-1:0] r_rem  [0:RB];
    logic [RB-1:0] r_root [0:RB];
    logic [30:0]   r_out;

    always_ff @(posedge i_clk) begin
        r_v[0]    <= i_sq;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar j = 0; j < RB; j++) begin : g_step
        localparam int P = RB - 1 - j;
        logic [MB+1:0] w_trial;
        logic [MB+1:0] w_test;
        logic          w_ge;

        assign w_trial = {r_rem[j], r_v[j][2*P+1 -: 2]};
        assign w_test  = {2'b00, r_root[j], 2'b01};
        assign w_ge    = w_trial >= w_test;

        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= w_ge ? MB'(w_trial - w_test) : w_trial[MB-1:0];
            r_root[j+1] <= {r_root[j][RB-2:0], w_ge};
            r_v[j+1]    <= r_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= r_root[RB][RB-1] ? 31'h7FFFFFFF : r_root[RB][30:0];
    end

    assign o_root = r_out;

endmodule

FILE: rtl/lbmc_coll.sv
// BGK equilibrium and relaxation datapath for fluid cells.
module lbmc_coll (
    input  logic              i_clk,
    input  logic [29:0]       i_relax,
    input  lbmc_pkg::t_word   i_ux,
    input  lbmc_pkg::t_word   i_uy,
    input  lbmc_pkg::t_word   i_rho,
    input  lbmc_pkg::t_dens   i_f,
    output logic [63:0]       o_sq,
    output lbmc_pkg::t_dens   o_f
);
    lbmc_pkg::t_word w_om;
    lbmc_pkg::t_word w_omd;

    // stage 1
    lbmc_pkg::t_word    r_s1_u [4];
    logic signed [63:0] r_s1_pxx, r_s1_pyy, r_s1_orho;
    logic signed [63:0] r_s1_fo [9];
    // stage 2
    logic signed [63:0] r_s2_kv [4];
    lbmc_pkg::t_word    r_s2_tp [4];
    lbmc_pkg::t_word    r_s2_tm [4];
    logic [63:0]        r_s2_sq;
    logic signed [63:0] r_s2_cp [3];
    lbmc_pkg::t_word    r_s2_fo [9];
    // stage 3
    logic signed [63:0] r_s3_mp [4];
    logic signed [63:0] r_s3_mm [4];
    logic signed [63:0] r_s3_dp;
    lbmc_pkg::t_word    r_s3_c  [3];
    lbmc_pkg::t_word    r_s3_fo [9];
    // stage 4
    lbmc_pkg::t_word    r_s4_d;
    lbmc_pkg::t_word    r_s4_mp [4];
    lbmc_pkg::t_word    r_s4_mm [4];
    lbmc_pkg::t_word    r_s4_c  [3];
    lbmc_pkg::t_word    r_s4_fo [9];
    // stage 5
    lbmc_pkg::t_word    r_s5_d;
    lbmc_pkg::t_word    r_s5_ep [4];
    lbmc_pkg::t_word    r_s5_em [4];
    lbmc_pkg::t_word    r_s5_c  [3];
    lbmc_pkg::t_word    r_s5_fo [9];
    // stage 6
    logic signed [63:0] r_s6_eq [9];
    lbmc_pkg::t_word    r_s6_fo [9];
    // stage 7
    lbmc_pkg::t_word    r_s7_eq [9];
    lbmc_pkg::t_word    r_s7_fo [9];
    // stage 8
    lbmc_pkg::t_dens    r_s8_f;

    assign w_om  = $signed({2'b00, i_relax});
    assign w_omd = lbmc_pkg::ONE_Q - w_om;

    always_ff @(posedge i_clk) begin
        r_s1_u[0] <= i_ux;
        r_s1_u[1] <= i_uy;
        r_s1_u[2] <= lbmc_pkg::sat_w(64'(i_ux) + 64'(i_uy));
        r_s1_u[3] <= lbmc_pkg::sat_w(64'(i_ux) - 64'(i_uy));
        r_s1_pxx  <= 64'(i_ux) * 64'(i_ux);
        r_s1_pyy  <= 64'(i_uy) * 64'(i_uy);
        r_s1_orho <= 64'(w_om) * 64'(i_rho);
        for (int i = 0; i < 9; i++) begin
            r_s1_fo[i] <= 64'($signed(i_f[i])) * 64'(w_omd);
        end
    end

    lbmc_pkg::t_word w_orho;
    assign w_orho = lbmc_pkg::mulq_fin(r_s1_orho);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_s2_kv[k] <= 64'(lbmc_pkg::K45_Q) * 64'(r_s1_u[k]);
            r_s2_tp[k] <= lbmc_pkg::sat_w(64'(lbmc_pkg::TWO3_Q) + 64'(r_s1_u[k]));
            r_s2_tm[k] <= lbmc_pkg::sat_w(64'(lbmc_pkg::TWO3_Q) - 64'(r_s1_u[k]));
        end
        r_s2_sq    <= r_s1_pxx + r_s1_pyy;
        r_s2_cp[0] <= 64'(w_orho) * 64'(lbmc_pkg::W0_Q);
        r_s2_cp[1] <= 64'(w_orho) * 64'(lbmc_pkg::W1_Q);
        r_s2_cp[2] <= 64'(w_orho) * 64'(lbmc_pkg::W2_Q);
        for (int i = 0; i < 9; i++) begin
            r_s2_fo[i] <= lbmc_pkg::mulq_fin(r_s1_fo[i]);
        end
    end

    lbmc_pkg::t_word w_usq;
    assign w_usq = lbmc_pkg::sat_w($signed(r_s2_sq >> lbmc_pkg::FRAC));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_s3_mp[k] <= 64'(lbmc_pkg::mulq_fin(r_s2_kv[k])) * 64'(r_s2_tp[k]);
            r_s3_mm[k] <= 64'(lbmc_pkg::mulq_fin(r_s2_kv[k])) * 64'(r_s2_tm[k]);
        end
        r_s3_dp <= 64'(w_usq) * 64'(lbmc_pkg::K15_Q);
        for (int j = 0; j < 3; j++) begin
            r_s3_c[j] <= lbmc_pkg::mulq_fin(r_s2_cp[j]);
        end
        r_s3_fo <= r_s2_fo;
    end

    always_ff @(posedge i_clk) begin
        r_s4_d <= lbmc_pkg::sat_w(64'(lbmc_pkg::ONE_Q)
                                  - 64'(lbmc_pkg::mulq_fin(r_s3_dp)));
        for (int k = 0; k < 4; k++) begin
            r_s4_mp[k] <= lbmc_pkg::mulq_fin(r_s3_mp[k]);
            r_s4_mm[k] <= lbmc_pkg::mulq_fin(r_s3_mm[k]);
        end
        r_s4_c  <= r_s3_c;
        r_s4_fo <= r_s3_fo;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_s5_ep[k] <= lbmc_pkg::sat_w(64'(r_s4_d) + 64'(r_s4_mp[k]));
            r_s5_em[k] <= lbmc_pkg::sat_w(64'(r_s4_d) - 64'(r_s4_mm[k]));
        end
        r_s5_d  <= r_s4_d;
        r_s5_c  <= r_s4_c;
        r_s5_fo <= r_s4_fo;
    end

    // axis directions use the w1 weight, diagonals w2
    always_ff @(posedge i_clk) begin
        r_s6_eq[0] <= 64'(r_s5_c[0]) * 64'(r_s5_d);
        for (int i = 1; i < 9; i++) begin
            r_s6_eq[i] <= 64'((i <= 4) ? r_s5_c[1] : r_s5_c[2])
                        * 64'(lbmc_pkg::eq_plus(i) ? r_s5_ep[lbmc_pkg::eq_vel(i)]
                                                   : r_s5_em[lbmc_pkg::eq_vel(i)]);
        end
        r_s6_fo <= r_s5_fo;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_s7_eq[i] <= lbmc_pkg::mulq_fin(r_s6_eq[i]);
        end
        r_s7_fo <= r_s6_fo;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_s8_f[i] <= lbmc_pkg::sat_w(64'(r_s7_eq[i]) + 64'(r_s7_fo[i]));
        end
    end

    assign o_sq = r_s2_sq;
    assign o_f  = r_s8_f;

endmodule

FILE: rtl/lbm_d2q9_cell_collision.sv
// Top level of the D2Q9 BGK cell collision pipeline.
//
//  port group      direction  handshake                 payload
//  command         in         start / busy              i_cell (t_cell_in)
//  result          out        o_done strobe, no stall   o_result (t_cell_out)
//  config (APB)    in/out     psel penable pwrite       paddr pwdata prdata pready
//
// One cell enters per cycle; busy is never raised.
// The 33-step divider and the 32-step square root set the depth of the pipeline.
// Halo cells leave no result.
// Reset clears the valid line and sets omega to 1.0; the datapath is not reset.
// The receiver cannot stall, so the pipeline always advances.
`include "lbm_d2q9_cell_collision_macros.svh"

module lbm_d2q9_cell_collision (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  lbmc_pkg::t_cell_in                     i_cell,
    output logic                                   o_done,
    output lbmc_pkg::t_cell_out                    o_result,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lbmc_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    localparam int LA = lbmc_pkg::LAT_ALIGN;
    localparam int LT = lbmc_pkg::LAT_T0;
    localparam int GB = lbmc_pkg::GRP_BITS;
    localparam int MB = lbmc_pkg::MOM_BITS;
    localparam int DB = lbmc_pkg::RHO_BITS;

    logic [29:0]             r_relax;
    logic                    w_wr;

    logic                    r_vld  [0:LA];
    lbmc_pkg::t_cell_in      r_cell [0:LA];

    logic signed [GB-1:0]    r_e, r_w, r_n, r_s, r_g;
    logic signed [MB-1:0]    r_mx, r_my;
    logic signed [DB-1:0]    r_rho;
    lbmc_pkg::t_word         r_rhos [0:lbmc_pkg::DIV_LAT-1];

    lbmc_pkg::t_word         w_ux, w_uy;
    logic [63:0]             w_sq;
    lbmc_pkg::t_dens         w_cf;
    logic [30:0]             w_spd;
    lbmc_pkg::t_dens         r_cdly [0:lbmc_pkg::ALIGN-1];

    lbmc_pkg::t_dens         w_in_f;
    lbmc_pkg::t_dens         w_bb;
    logic                    w_obst;
    logic                    r_done;
    lbmc_pkg::t_cell_out     r_result;

    // configuration
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == lbmc_pkg::REG_RELAX) ? {2'b00, r_relax} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax <= lbmc_pkg::RELAX_RESET;
        end else if (w_wr && (paddr[2] == lbmc_pkg::REG_RELAX)) begin
            r_relax <= pwdata[29:0];
        end
    end

    assign busy = 1'b0;

    // valid line: drop halo cells at the door
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p <= LA; p++) r_vld[p] <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy && (i_cell.cell_kind != lbmc_pkg::KIND_HALO);
            for (int p = 1; p <= LA; p++) r_vld[p] <= r_vld[p-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell[0] <= i_cell;
        for (int p = 1; p <= LA; p++) r_cell[p] <= r_cell[p-1];
    end

    // density and momentum sums over two stages
    always_ff @(posedge i_clk) begin
        r_e <= GB'(r_cell[0].in_east) + GB'(r_cell[0].in_northeast)
             + GB'(r_cell[0].in_southeast);
        r_w <= GB'(r_cell[0].in_west) + GB'(r_cell[0].in_northwest)
             + GB'(r_cell[0].in_southwest);
        r_n <= GB'(r_cell[0].in_north) + GB'(r_cell[0].in_northeast)
             + GB'(r_cell[0].in_northwest);
        r_s <= GB'(r_cell[0].in_south) + GB'(r_cell[0].in_southwest)
             + GB'(r_cell[0].in_southeast);
        r_g <= GB'(r_cell[0].in_rest) + GB'(r_cell[0].in_north)
             + GB'(r_cell[0].in_south);
    end

    always_ff @(posedge i_clk) begin
        r_mx  <= MB'(r_e) - MB'(r_w);
        r_my  <= MB'(r_n) - MB'(r_s);
        r_rho <= DB'(r_g) + DB'(r_e) + DB'(r_w);
    end

    // hold saturated density until the velocities come out of the dividers
    always_ff @(posedge i_clk) begin
        r_rhos[0] <= lbmc_pkg::sat_w(64'(r_rho));
        for (int p = 1; p < lbmc_pkg::DIV_LAT; p++) r_rhos[p] <= r_rhos[p-1];
    end

    lbmc_div u_div_x (
        .i_clk (i_clk),
        .i_num (r_mx),
        .i_den (r_rho),
        .o_quo (w_ux)
    );

    lbmc_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_my),
        .i_den (r_rho),
        .o_quo (w_uy)
    );

    assign w_in_f = lbmc_pkg::cell_dens(r_cell[LT]);

    lbmc_coll u_coll (
        .i_clk   (i_clk),
        .i_relax (r_relax),
        .i_ux    (w_ux),
        .i_uy    (w_uy),
        .i_rho   (r_rhos[lbmc_pkg::DIV_LAT-1]),
        .i_f     (w_in_f),
        .o_sq    (w_sq),
        .o_f     (w_cf)
    );

    lbmc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_sq   (w_sq),
        .o_root (w_spd)
    );

    always_ff @(posedge i_clk) begin
        r_cdly[0] <= w_cf;
        for (int p = 1; p < lbmc_pkg::ALIGN; p++) r_cdly[p] <= r_cdly[p-1];
    end

    // bounce-back swaps opposite directions
    always_comb begin
        lbmc_pkg::t_dens f;
        f = lbmc_pkg::cell_dens(r_cell[LA]);
        for (int i = 0; i < 9; i++) w_bb[i] = f[lbmc_pkg::opp_dir(i)];
    end

    assign w_obst = (r_cell[LA].cell_kind != lbmc_pkg::KIND_FLUID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[LA];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= w_obst ? lbmc_pkg::make_out(w_bb, 31'd0)
                           : lbmc_pkg::make_out(r_cdly[lbmc_pkg::ALIGN-1], w_spd);
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `LBMC_CHECK(a_fluid_result, start && (i_cell.cell_kind == lbmc_pkg::KIND_FLUID) |-> ##75 o_done, "fluid cell lost its result")
    `LBMC_CHECK(a_halo_silent, start && (i_cell.cell_kind == lbmc_pkg::KIND_HALO) |-> ##75 !o_done, "halo cell produced a result")
    `LBMC_CHECK(a_obst_speed, r_vld[LA] && w_obst |=> o_done && (o_result.cell_speed == 31'd0), "obstacle speed not zero")
    `LBMC_CHECK(a_relax_write, w_wr && (paddr[2] == lbmc_pkg::REG_RELAX) |=> r_relax == $past(pwdata[29:0]), "relax rate write lost")

endmodule
